// ===== hw/rtl/sqi_pkg.sv =====
// ----------------------------------------------------------------------------
// sqi_pkg
// Shared constants and codes for the segment and portal crossing test.
// ----------------------------------------------------------------------------
package sqi_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CHUNK_BITS = 24;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTRE_X        = 3'd0,
    REG_CENTRE_Y        = 3'd1,
    REG_CENTRE_Z        = 3'd2,
    REG_FACING          = 3'd3,
    REG_EXTENT_VERTICAL = 3'd4,
    REG_EXTENT_SIDE     = 3'd5
  } cfg_reg_t;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Z = 3'd2;
  localparam logic [2:0] FACE_NEG_Z = 3'd3;

endpackage

// ===== hw/rtl/sqi_channels.sv =====
// ----------------------------------------------------------------------------
// sqi channels
// Valid/ready channels for segment queries and crossing results.
// ----------------------------------------------------------------------------
interface sqi_in_if #(
  parameter int W = sqi_pkg::COORD_BITS
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] start_z;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  logic signed [W-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface sqi_out_if;
  logic valid;
  logic ready;
  logic crosses;

  modport source (output valid, crosses, input ready);
  modport sink (input valid, crosses, output ready);
endinterface

// ===== hw/rtl/sqi_wmul.sv =====
// ----------------------------------------------------------------------------
// sqi_wmul
// Two-stage wide multiplier: signed by unsigned, split into chunk products.
// ----------------------------------------------------------------------------
module sqi_wmul #(
  parameter int WA = 70,
  parameter int WB = 31,
  parameter int CW = sqi_pkg::CHUNK_BITS
) (
  input  logic                    clk,
  input  logic                    en_pp,
  input  logic                    en_sum,
  input  logic signed [WA-1:0]    a,
  input  logic        [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NC = (WA + CW - 1) / CW;
  localparam int WX = NC * CW;
  localparam int WT = WX + WB + 1;

  logic signed [WX-1:0]   ax;
  logic signed [CW+WB:0]  pp [NC];
  logic signed [WT-1:0]   acc;

  assign ax = WX'(a);

  always_ff @(posedge clk) begin
    if (en_pp) begin
      for (int i = 0; i < NC; i++) begin
        if (i == NC - 1) begin
          pp[i] <= $signed(ax[i*CW +: CW]) * $signed({1'b0, b});
        end else begin
          pp[i] <= $signed({1'b0, ax[i*CW +: CW]}) * $signed({1'b0, b});
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NC; i++) begin
      acc = acc + (WT'(pp[i]) <<< (i * CW));
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      p <= acc[WA+WB-1:0];
    end
  end

endmodule

// ===== hw/rtl/segment_quad_intersect.sv =====
// ----------------------------------------------------------------------------
// segment_quad_intersect
// Tests whether a line segment crosses a rectangular, axis-aligned portal.
// ----------------------------------------------------------------------------
// The block takes one segment transaction per clock while the output is not
// stalled and returns one crossing flag per segment, in order. All
// multiplications are pipelined: the wide products are formed from chunk
// products in one stage and summed in the next, so the rate is one
// transaction per cycle when the output is not stalled. Stages advance
// independently, so bubbles are squeezed out while the output waits.
// Configuration must be written only while no transaction is in flight.
module segment_quad_intersect #(
  parameter int COORD_BITS = sqi_pkg::COORD_BITS,
  parameter int FRAC_BITS  = sqi_pkg::FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sqi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_data,
  sqi_in_if.sink                            in_ch,
  sqi_out_if.source                         out_ch
);

  localparam int CB = COORD_BITS;
  localparam int WE = CB - 1;
  localparam int WS = CB + 2;
  localparam int WP = 2 * WS;
  localparam int WK = WP + 2;
  localparam int WV = WS + CB;
  localparam int WD = WK + WE + 1;
  localparam int WM = WD + 4;

  logic signed [CB-1:0] centre_x;
  logic signed [CB-1:0] centre_y;
  logic signed [CB-1:0] centre_z;
  logic [2:0]           facing;
  logic [WE-1:0]        extent_vertical;
  logic [WE-1:0]        extent_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x        <= '0;
      centre_y        <= '0;
      centre_z        <= '0;
      facing          <= sqi_pkg::FACE_POS_X;
      extent_vertical <= {{(WE-1){1'b0}}, 1'b1} << FRAC_BITS;
      extent_side     <= {{(WE-1){1'b0}}, 1'b1} << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (sqi_pkg::cfg_reg_t'(cfg_index))
        sqi_pkg::REG_CENTRE_X:        centre_x <= cfg_data;
        sqi_pkg::REG_CENTRE_Y:        centre_y <= cfg_data;
        sqi_pkg::REG_CENTRE_Z:        centre_z <= cfg_data;
        sqi_pkg::REG_FACING:          facing <= cfg_data[2:0];
        sqi_pkg::REG_EXTENT_VERTICAL: extent_vertical <= cfg_data[WE-1:0];
        sqi_pkg::REG_EXTENT_SIDE:     extent_side <= cfg_data[WE-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic [7:1] vld;
  logic [8:1] en;

  always_comb begin
    en[8] = out_ch.ready;
    for (int k = 7; k >= 1; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign in_ch.ready  = en[1];
  assign out_ch.valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_ch.valid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: differences, facing selection and sign folding.
  logic signed [CB:0] dlt_x, dlt_y, dlt_z, rel_x, rel_y, rel_z;
  logic signed [CB:0] dn, rn, dsd, gsd;
  logic               n_is_z, n_neg, s_neg;

  assign dlt_x = (CB+1)'(in_ch.start_x) - (CB+1)'(in_ch.end_x);
  assign dlt_y = (CB+1)'(in_ch.start_y) - (CB+1)'(in_ch.end_y);
  assign dlt_z = (CB+1)'(in_ch.start_z) - (CB+1)'(in_ch.end_z);
  assign rel_x = (CB+1)'(in_ch.start_x) - (CB+1)'(centre_x);
  assign rel_y = (CB+1)'(in_ch.start_y) - (CB+1)'(centre_y);
  assign rel_z = (CB+1)'(in_ch.start_z) - (CB+1)'(centre_z);

  always_comb begin
    case (facing)
      sqi_pkg::FACE_NEG_X: begin
        n_is_z = 1'b0; n_neg = 1'b1; s_neg = 1'b1;
      end
      sqi_pkg::FACE_POS_Z: begin
        n_is_z = 1'b1; n_neg = 1'b0; s_neg = 1'b1;
      end
      sqi_pkg::FACE_NEG_Z: begin
        n_is_z = 1'b1; n_neg = 1'b1; s_neg = 1'b0;
      end
      default: begin
        n_is_z = 1'b0; n_neg = 1'b0; s_neg = 1'b0;
      end
    endcase
  end

  assign dn  = n_is_z ? dlt_z : dlt_x;
  assign rn  = n_is_z ? rel_z : rel_x;
  assign dsd = n_is_z ? dlt_x : dlt_z;
  assign gsd = n_is_z ? rel_x : rel_z;

  logic signed [WS-1:0] s1_p, s1_r, s1_ds, s1_gs, s1_dy, s1_gy;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_p  <= n_neg ? -WS'(dn) : WS'(dn);
      s1_r  <= n_neg ? -WS'(rn) : WS'(rn);
      s1_ds <= s_neg ? -WS'(dsd) : WS'(dsd);
      s1_gs <= s_neg ? -WS'(gsd) : WS'(gsd);
      s1_dy <= WS'(dlt_y);
      s1_gy <= WS'(rel_y);
    end
  end

  // Stage 2: cross products, scaled extents and the range test on t.
  logic signed [WS+4:0] t_ten, t_lo, t_hi;
  logic signed [WP-1:0] s2_pgs, s2_rds, s2_pgy, s2_rdy;
  logic signed [WV-1:0] s2_vp, s2_ep;
  logic                 s2_ok;

  assign t_ten = ((WS+5)'(s1_r) <<< 3) + ((WS+5)'(s1_r) <<< 1);
  assign t_lo  = t_ten + ((WS+5)'(s1_p) <<< 1) + (WS+5)'(s1_p);
  assign t_hi  = ((WS+5)'(s1_p) <<< 3) + ((WS+5)'(s1_p) <<< 2) + (WS+5)'(s1_p) - t_ten;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_pgs <= s1_p * s1_gs;
      s2_rds <= s1_r * s1_ds;
      s2_pgy <= s1_p * s1_gy;
      s2_rdy <= s1_r * s1_dy;
      s2_vp  <= s1_p * $signed({1'b0, extent_vertical});
      s2_ep  <= s1_p * $signed({1'b0, extent_side});
      s2_ok  <= (s1_p > 0) && (extent_vertical != '0) && (extent_side != '0) &&
                !t_lo[WS+4] && !t_hi[WS+4];
    end
  end

  // Stage 3: hit point offsets within the portal plane.
  logic signed [WK-1:0] s3_k, s3_l;
  logic signed [WV-1:0] s3_vp, s3_ep;
  logic                 s3_ok;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_k  <= (WK'(s2_pgs) - WK'(s2_rds)) <<< 1;
      s3_l  <= (WK'(s2_pgy) - WK'(s2_rdy)) <<< 1;
      s3_vp <= s2_vp;
      s3_ep <= s2_ep;
      s3_ok <= s2_ok;
    end
  end

  // Stage 4: bounds along side and up; wide products start.
  logic signed [WK+4:0] k5, l5, ep8, vp8, a_lo, a_hi, b_lo, b_hi;
  logic                 s4_ok, s4_aok, s4_blo, s4_bhi;

  assign k5   = ((WK+5)'(s3_k) <<< 2) + (WK+5)'(s3_k);
  assign l5   = ((WK+5)'(s3_l) <<< 2) + (WK+5)'(s3_l);
  assign ep8  = (WK+5)'(s3_ep) <<< 3;
  assign vp8  = (WK+5)'(s3_vp) <<< 3;
  assign a_lo = k5 + ep8;
  assign a_hi = ep8 - k5;
  assign b_lo = l5 + vp8;
  assign b_hi = vp8 - l5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_ok  <= s3_ok;
      s4_aok <= !a_lo[WK+4] && !a_hi[WK+4];
      s4_blo <= !b_lo[WK+4];
      s4_bhi <= !b_hi[WK+4];
    end
  end

  logic signed [WK+WE-1:0] kv, le;
  logic signed [WV+WE-1:0] qv;

  sqi_wmul #(.WA(WK), .WB(WE)) u_kv (
    .clk(clk), .en_pp(en[4]), .en_sum(en[5]), .a(s3_k), .b(extent_vertical), .p(kv)
  );

  sqi_wmul #(.WA(WK), .WB(WE)) u_le (
    .clk(clk), .en_pp(en[4]), .en_sum(en[5]), .a(s3_l), .b(extent_side), .p(le)
  );

  sqi_wmul #(.WA(WV), .WB(WE)) u_q (
    .clk(clk), .en_pp(en[4]), .en_sum(en[5]), .a(s3_vp), .b(extent_side), .p(qv)
  );

  // Stage 5: flags travel beside the product sums.
  logic s5_ok, s5_aok, s5_blo, s5_bhi;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_ok  <= s4_ok;
      s5_aok <= s4_aok;
      s5_blo <= s4_blo;
      s5_bhi <= s4_bhi;
    end
  end

  // Stage 6: diagonal term and scaled area.
  logic signed [WM-1:0] s6_d, s6_q3, s6_q13;
  logic                 s6_ok, s6_blo, s6_bhi;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_d   <= WM'(kv) - WM'(le);
      s6_q3  <= (WM'(qv) <<< 1) + WM'(qv);
      s6_q13 <= (WM'(qv) <<< 3) + (WM'(qv) <<< 2) + WM'(qv);
      s6_ok  <= s5_ok && s5_aok;
      s6_blo <= s5_blo;
      s6_bhi <= s5_bhi;
    end
  end

  // Stage 7: triangle tests and result register.
  logic signed [WM-1:0] d5, c0, c1, c2;
  logic                 s7_crosses;

  assign d5 = (s6_d <<< 2) + s6_d;
  assign c0 = s6_q3 - d5;
  assign c1 = d5 + s6_q3;
  assign c2 = s6_q13 - d5;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_crosses <= s6_ok && s6_blo &&
                    ((s6_bhi && !c0[WM-1]) || (!c1[WM-1] && !c2[WM-1]));
    end
  end

  assign out_ch.crosses = s7_crosses;

`ifndef NO_ASSERTIONS
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (vld == '1 && !out_ch.ready) |-> !in_ch.ready)
    else $error("transaction accepted while pipeline is full and stalled");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && en[2]) |=> vld[2])
    else $error("transaction lost between first and second stage");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (vld[7] && !out_ch.ready) |=> (vld[7] && $stable(s7_crosses)))
    else $error("stalled result changed or dropped");
`endif

endmodule

// ===== sim/sqi_checker.sv =====
// ----------------------------------------------------------------------------
// sqi_checker
// Watches the configuration port and both channels of the portal crossing
// block. It works out the expected crossing flag of every accepted segment
// with exact wide integer arithmetic and compares it with the returned flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqi_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  sqi_in_if           in_mon,
  sqi_out_if          out_mon,
  output int          errors,
  output int          pending
);

  typedef logic signed [191:0] wide_t;

  logic signed [31:0] centre_x, centre_y, centre_z;
  logic [2:0]         facing;
  logic [30:0]        extent_v, extent_s;
  bit                 expected_crossing[$];
  longint             seg_start[3], seg_end[3];
  bit                 want;

  function automatic wide_t det3(input longint a[3], input longint b[3],
                                 input longint c[3]);
    wide_t x, y, z;
    x = wide_t'(b[1]) * wide_t'(c[2]) - wide_t'(b[2]) * wide_t'(c[1]);
    y = wide_t'(b[2]) * wide_t'(c[0]) - wide_t'(b[0]) * wide_t'(c[2]);
    z = wide_t'(b[0]) * wide_t'(c[1]) - wide_t'(b[1]) * wide_t'(c[0]);
    return wide_t'(a[0]) * x + wide_t'(a[1]) * y + wide_t'(a[2]) * z;
  endfunction

  // The ratio n/d, with d positive, must lie within [-0.3, 1.3].
  function automatic bit within_slack(input wide_t n, input wide_t d);
    wide_t lo, hi;
    lo = 10 * n + 3 * d;
    hi = 13 * d - 10 * n;
    return lo >= 0 && hi >= 0;
  endfunction

  function automatic bit predict_crossing(input longint a[3], input longint b[3]);
    int     nax, nsg, sax, ssg;
    longint ctr[3], p[4][3], d[3], e1[3], e2[3], r[3];
    wide_t  det, dt, du, dv, uv;
    bit     hit;
    hit = 0;
    case (facing)
      sqi_pkg::FACE_NEG_X: begin nax = 0; nsg = -1; sax = 2; ssg = -1; end
      sqi_pkg::FACE_POS_Z: begin nax = 2; nsg = 1;  sax = 0; ssg = -1; end
      sqi_pkg::FACE_NEG_Z: begin nax = 2; nsg = -1; sax = 0; ssg = 1;  end
      default:             begin nax = 0; nsg = 1;  sax = 2; ssg = 1;  end
    endcase
    if (a[0] == b[0] && a[1] == b[1] && a[2] == b[2]) return 0;
    if ((b[nax] - a[nax]) * nsg > 0) return 0;
    ctr[0] = longint'(centre_x);
    ctr[1] = longint'(centre_y);
    ctr[2] = longint'(centre_z);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) p[k][i] = 2 * ctr[i];
      p[k][1] += (k < 2) ? longint'(extent_v) : -longint'(extent_v);
      p[k][sax] += ((k & 1) ? longint'(extent_s) : -longint'(extent_s)) * ssg;
    end
    for (int i = 0; i < 3; i++) d[i] = 2 * (a[i] - b[i]);
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] = p[k + 1][i] - p[k][i];
        e2[i] = p[k + 2][i] - p[k][i];
        r[i]  = 2 * a[i] - p[k][i];
      end
      det = det3(d, e1, e2);
      if (det == 0) continue;
      dt = det3(r, e1, e2);
      du = det3(d, r, e2);
      dv = det3(d, e1, r);
      if (det < 0) begin
        det = -det;
        dt = -dt;
        du = -du;
        dv = -dv;
      end
      if (within_slack(dt, det) && within_slack(du, det) && within_slack(dv, det)) begin
        uv = 10 * (du + dv);
        if (13 * det - uv >= 0) hit = 1;
      end
    end
    return hit;
  endfunction

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      centre_x = '0;
      centre_y = '0;
      centre_z = '0;
      facing   = sqi_pkg::FACE_POS_X;
      extent_v = 31'd1 << sqi_pkg::FRAC_BITS;
      extent_s = 31'd1 << sqi_pkg::FRAC_BITS;
      errors   = 0;
      expected_crossing.delete();
    end else begin
      if (cfg_we) begin
        case (sqi_pkg::cfg_reg_t'(cfg_index))
          sqi_pkg::REG_CENTRE_X:        centre_x = cfg_data;
          sqi_pkg::REG_CENTRE_Y:        centre_y = cfg_data;
          sqi_pkg::REG_CENTRE_Z:        centre_z = cfg_data;
          sqi_pkg::REG_FACING:          facing   = cfg_data[2:0];
          sqi_pkg::REG_EXTENT_VERTICAL: extent_v = cfg_data[30:0];
          sqi_pkg::REG_EXTENT_SIDE:     extent_s = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        seg_start[0] = longint'(in_mon.start_x);
        seg_start[1] = longint'(in_mon.start_y);
        seg_start[2] = longint'(in_mon.start_z);
        seg_end[0]   = longint'(in_mon.end_x);
        seg_end[1]   = longint'(in_mon.end_y);
        seg_end[2]   = longint'(in_mon.end_z);
        expected_crossing.push_back(predict_crossing(seg_start, seg_end));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_crossing.size() == 0) begin
          report("result transaction with no segment outstanding");
        end else begin
          want = expected_crossing.pop_front();
          if (out_mon.crosses !== want)
            report($sformatf("crosses %b, expected %b", out_mon.crosses, want));
        end
      end
    end
    pending = expected_crossing.size();
  end
endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives segment queries into the portal crossing block under several portal
// settings, with random gaps and stalls on both channels, and gives the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam longint ONE = 64'd1 << sqi_pkg::FRAC_BITS;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES = 12;
  localparam int PHASE_SEGMENTS = 160;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          errors, pending;
  int          quiet_cycles = 0;
  int          hold_cycles = 0;
  bit          source_gaps = 1;
  bit          sink_gaps = 1;
  longint      cur_centre[3];
  longint      cur_ext_v, cur_ext_s;
  logic [2:0]  cur_facing;

  sqi_in_if  in_ch ();
  sqi_out_if out_ch ();

  segment_quad_intersect dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sqi_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid   = 0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.start_z = '0;
    in_ch.end_x   = '0;
    in_ch.end_y   = '0;
    in_ch.end_z   = '0;
    out_ch.ready  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= !sink_gaps || $urandom_range(99) >= 32;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic put_reg(input sqi_pkg::cfg_reg_t idx, input logic [31:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_portal(input longint x, input longint y,
                            input longint z, input longint f,
                            input longint ev, input longint es);
    put_reg(sqi_pkg::REG_CENTRE_X, x[31:0]);
    put_reg(sqi_pkg::REG_CENTRE_Y, y[31:0]);
    put_reg(sqi_pkg::REG_CENTRE_Z, z[31:0]);
    put_reg(sqi_pkg::REG_FACING, {29'd0, f[2:0]});
    put_reg(sqi_pkg::REG_EXTENT_VERTICAL, ev[31:0]);
    put_reg(sqi_pkg::REG_EXTENT_SIDE, es[31:0]);
    cfg_we <= 0;
    @(posedge clk);
    cur_centre[0] = longint'($signed(x[31:0]));
    cur_centre[1] = longint'($signed(y[31:0]));
    cur_centre[2] = longint'($signed(z[31:0]));
    cur_facing = f[2:0];
    cur_ext_v = longint'(ev[30:0]);
    cur_ext_s = longint'(es[30:0]);
  endtask

  task automatic send_segment(input longint sx, input longint sy, input longint sz,
                              input longint ex, input longint ey, input longint ez);
    if (source_gaps && $urandom_range(99) < 32) begin
      in_ch.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    in_ch.valid <= 1;
    in_ch.start_x <= sx[31:0];
    in_ch.start_y <= sy[31:0];
    in_ch.start_z <= sz[31:0];
    in_ch.end_x <= ex[31:0];
    in_ch.end_y <= ey[31:0];
    in_ch.end_z <= ez[31:0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic longint jitter(input longint span);
    longint s;
    s = (span > (64'd1 << 30)) ? (64'd1 << 30) : span;
    return longint'($urandom_range(0, 32'(2 * s))) - s;
  endfunction

  // A segment near the portal, heading against the normal unless reversed.
  task automatic near_segment(input bit reversed);
    int     nax, sax, nsg;
    longint st[3], en[3], lateral;
    nax = (cur_facing == sqi_pkg::FACE_POS_Z || cur_facing == sqi_pkg::FACE_NEG_Z) ? 2 : 0;
    sax = 2 - nax;
    nsg = (cur_facing == sqi_pkg::FACE_NEG_X || cur_facing == sqi_pkg::FACE_NEG_Z) ? -1 : 1;
    if (reversed) nsg = -nsg;
    lateral = jitter(cur_ext_v / 2 + cur_ext_v / 4 + 2);
    st[1] = cur_centre[1] + lateral;
    en[1] = cur_centre[1] + lateral + jitter(cur_ext_v / 8 + 1);
    lateral = jitter(cur_ext_s / 2 + cur_ext_s / 4 + 2);
    st[sax] = cur_centre[sax] + lateral;
    en[sax] = cur_centre[sax] + lateral + jitter(cur_ext_s / 8 + 1);
    st[nax] = cur_centre[nax] + nsg * longint'($urandom_range(0, 4 * ONE));
    en[nax] = cur_centre[nax] - nsg * longint'($urandom_range(1, 4 * ONE));
    send_segment(st[0], st[1], st[2], en[0], en[1], en[2]);
  endtask

  task automatic random_segment();
    int     pick;
    longint px, py, pz;
    pick = $urandom_range(99);
    if (pick < 65) begin
      near_segment(0);
    end else if (pick < 85) begin
      send_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 92) begin
      px = cur_centre[0] + jitter(ONE);
      py = cur_centre[1] + jitter(ONE);
      pz = cur_centre[2] + jitter(ONE);
      send_segment(px, py, pz, px, py, pz);
    end else begin
      near_segment(1);
    end
  endtask

  initial begin
    cur_centre = '{0, 0, 0};
    cur_facing = sqi_pkg::FACE_POS_X;
    cur_ext_v = ONE;
    cur_ext_s = ONE;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_segment(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE);
    send_segment(-ONE, 0, 0, ONE, 0, 0);
    send_segment(ONE, 0, 0, -ONE, 0, 0);
    send_segment(ONE / 2, 0, -ONE, ONE / 2, 0, ONE);
    send_segment(ONE, 3 * ONE, 0, -ONE, 3 * ONE, 0);
    send_segment(ONE, ONE * 6 / 10, 0, -ONE, ONE * 6 / 10, 0);
    send_segment(ONE, ONE * 9 / 10, ONE * 9 / 10, -ONE, ONE * 9 / 10, ONE * 9 / 10);
    send_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000);
    send_segment(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_segment(0, 0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_segment(32'h7fffffff, 0, 0, 32'h80000000, 0, 0);
    in_ch.valid <= 0;
    drain();

    for (int f = 0; f < 8; f++) begin
      set_portal(ONE * f, -ONE, 2 * ONE, f, 2 * ONE, 3 * ONE);
      for (int i = 0; i < 2; i++) near_segment(i[0]);
      in_ch.valid <= 0;
      drain();
    end

    set_portal(0, 0, 0, sqi_pkg::FACE_POS_X, 0, ONE);
    near_segment(0);
    near_segment(0);
    in_ch.valid <= 0;
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      source_gaps = (ph != 3);
      sink_gaps = (ph != 3);
      case (ph)
        0: set_portal(32'h7fffffff, 32'h80000000, 32'h7fffffff, sqi_pkg::FACE_NEG_X,
                      32'h7fffffff, 32'hffffffff);
        1: set_portal(32'h80000000, 32'h7fffffff, 32'h80000000, sqi_pkg::FACE_NEG_Z,
                      0, 0);
        default: begin
          if ($urandom_range(3) == 0)
            set_portal($urandom, $urandom, $urandom, $urandom_range(7),
                       $urandom, $urandom);
          else
            set_portal(jitter(64'd1 << 24), jitter(64'd1 << 24), jitter(64'd1 << 24),
                       $urandom_range(7), $urandom_range(1, 1 << 20),
                       $urandom_range(1, 1 << 20) | ($urandom_range(1) << 31));
        end
      endcase
      if (ph == 5) hold_cycles = 400;
      for (int i = 0; i < PHASE_SEGMENTS; i++) random_segment();
      in_ch.valid <= 0;
      drain();
    end

    source_gaps = 1;
    sink_gaps = 1;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
